// ===== design/msp_pkg.sv =====
package msp_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int VAL_W      = 32;
  localparam int IDX_OUT_W  = 4;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int UPC_W      = 4;

  localparam logic [KIND_W-1:0] KIND_ROW_MIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROW_MAX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PASS0,
    OP_ROWINIT,
    OP_SCAN,
    OP_COLINIT,
    OP_CHECK,
    OP_EMIT,
    OP_NEXTROW,
    OP_PASS1,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_START,
    C_LOOP,
    C_EMIT_BLK,
    C_ROW_MORE,
    C_PASS0,
    C_OUT_BUSY
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t ST_IDLE    = 4'd0;
  localparam upc_t ST_PASS0   = 4'd1;
  localparam upc_t ST_ROWINIT = 4'd2;
  localparam upc_t ST_SCAN    = 4'd3;
  localparam upc_t ST_COLINIT = 4'd4;
  localparam upc_t ST_CHECK   = 4'd5;
  localparam upc_t ST_EMIT    = 4'd6;
  localparam upc_t ST_NEXTROW = 4'd7;
  localparam upc_t ST_PASS1   = 4'd8;
  localparam upc_t ST_FINISH  = 4'd9;
  localparam upc_t ST_RET     = 4'd10;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic idle;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic loop_more;
    logic emit_blk;
    logic row_more;
    logic pass0;
    logic out_busy;
  } stat_t;

  // jump to target when cond holds, else fall through
  function automatic uword_t ucode_rom(upc_t a);
    uword_t w;
    case (a)
      ST_IDLE:    w = '{OP_NONE,    C_NO_START, ST_IDLE};
      ST_PASS0:   w = '{OP_PASS0,   C_ALWAYS,   ST_ROWINIT};
      ST_ROWINIT: w = '{OP_ROWINIT, C_ALWAYS,   ST_SCAN};
      ST_SCAN:    w = '{OP_SCAN,    C_LOOP,     ST_SCAN};
      ST_COLINIT: w = '{OP_COLINIT, C_ALWAYS,   ST_CHECK};
      ST_CHECK:   w = '{OP_CHECK,   C_LOOP,     ST_CHECK};
      ST_EMIT:    w = '{OP_EMIT,    C_EMIT_BLK, ST_EMIT};
      ST_NEXTROW: w = '{OP_NEXTROW, C_ROW_MORE, ST_ROWINIT};
      ST_PASS1:   w = '{OP_PASS1,   C_PASS0,    ST_ROWINIT};
      ST_FINISH:  w = '{OP_FINISH,  C_OUT_BUSY, ST_FINISH};
      ST_RET:     w = '{OP_NONE,    C_ALWAYS,   ST_IDLE};
      default:    w = '{OP_NONE,    C_ALWAYS,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/matrix_saddle_point_finder_unit.sv =====
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    in_element_value[31:0] signed
// out      out  out_valid / out_ready  out_point_value, out_row_index, out_col_index,
//                                      out_kind, out_last_result
// cfg      in   cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[4:0]
//
// Loading takes back-to-back elements; in_ready is high while the sequencer idles.
// After the last element, the search walks each row, then its column, through the
// single store read port.
// Stalls on out_ready hold the search when a new result meets a full output and pending register.
// Synchronous active-low reset; the store needs no clearing after reset.
module matrix_saddle_point_finder_unit
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int NRW = $clog2(MAX_ROWS + 1),
  localparam int NCW = $clog2(MAX_COLS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_element_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_point_value,
  output logic [IDX_OUT_W-1:0]    out_row_index,
  output logic [IDX_OUT_W-1:0]    out_col_index,
  output logic [KIND_W-1:0]       out_kind,
  output logic                    out_last_result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [CFG_DATA_W-1:0] rows_r, rows_nxt;
  logic [CFG_DATA_W-1:0] cols_r, cols_nxt;
  logic                  cfg_restart;
  logic [NRW-1:0]        nr;
  logic [NCW-1:0]        nc;
  ctl_t                  ctl;
  stat_t                 stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    rows_nxt    = rows_r;
    cols_nxt    = cols_r;
    cfg_restart = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS: begin
          rows_nxt    = cfg_data;
          cfg_restart = 1'b1;
        end
        REG_COLS: begin
          cols_nxt    = cfg_data;
          cfg_restart = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_RESET;
      cols_r <= SIZE_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // zero counts as one, above the maximum counts as the maximum
  assign nr = (rows_r == '0) ? NRW'(1) :
              (8'(rows_r) > 8'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_r);
  assign nc = (cols_r == '0) ? NCW'(1) :
              (8'(cols_r) > 8'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_r);

  msp_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  msp_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .nr               (nr),
    .nc               (nc),
    .cfg_restart      (cfg_restart),
    .ctl              (ctl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_value  (out_point_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_kind         (out_kind),
    .out_last_result  (out_last_result)
  );

endmodule

// ===== design/msp_ram.sv =====
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/msp_useq.sv =====
module msp_useq
  import msp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctl_t  ctl
);

  upc_t   upc_r, upc_nxt;
  uword_t w;
  logic   hit;

  assign w = ucode_rom(upc_r);

  always_comb begin
    case (w.cond)
      C_ALWAYS:   hit = 1'b1;
      C_NO_START: hit = !stat.start;
      C_LOOP:     hit = stat.loop_more;
      C_EMIT_BLK: hit = stat.emit_blk;
      C_ROW_MORE: hit = stat.row_more;
      C_PASS0:    hit = stat.pass0;
      C_OUT_BUSY: hit = stat.out_busy;
      default:    hit = 1'b1;
    endcase
    upc_nxt = hit ? w.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctl.op   = w.op;
  assign ctl.idle = (upc_r == ST_IDLE);

endmodule

// ===== design/msp_dp.sv =====
module msp_dp
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int NRW   = $clog2(MAX_ROWS + 1),
  localparam int NCW   = $clog2(MAX_COLS + 1),
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LPW   = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [NRW-1:0]              nr,
  input  logic [NCW-1:0]              nc,
  input  logic                        cfg_restart,
  input  ctl_t                        ctl,
  output stat_t                       stat,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [VAL_W-1:0]     in_element_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VAL_W-1:0]     out_point_value,
  output logic [IDX_OUT_W-1:0]        out_row_index,
  output logic [IDX_OUT_W-1:0]        out_col_index,
  output logic [KIND_W-1:0]           out_kind,
  output logic                        out_last_result
);

  // load side
  logic [RIW-1:0] lr_r, lr_nxt;
  logic [CIW-1:0] lc_r, lc_nxt;
  logic           in_acc, row_end, is_last;

  // search side
  logic                    pass_r, pass_nxt;
  logic [RIW-1:0]          r_r, r_nxt;
  logic [LPW-1:0]          i_r, i_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic [CIW-1:0]          bc_r, bc_nxt;
  logic                    ok_r, ok_nxt;

  // pending result (held until the next one decides its last flag)
  logic                    pend_valid_r, pend_valid_nxt;
  logic signed [VAL_W-1:0] pend_val_r, pend_val_nxt;
  logic [IDX_OUT_W-1:0]    pend_row_r, pend_row_nxt;
  logic [IDX_OUT_W-1:0]    pend_col_r, pend_col_nxt;
  logic [KIND_W-1:0]       pend_kind_r, pend_kind_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [IDX_OUT_W-1:0]    out_row_r, out_row_nxt;
  logic [IDX_OUT_W-1:0]    out_col_r, out_col_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [AW-1:0]           waddr, raddr;
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W-1:0] rd_val;
  logic [RIW-1:0]          rd_row;
  logic [CIW-1:0]          rd_col;
  logic                    better, worse, out_free, emit_blk;

  assign in_ready = ctl.idle;
  assign in_acc   = in_valid && ctl.idle;
  assign row_end  = (NCW'(lc_r) + NCW'(1)) == nc;
  assign is_last  = row_end && ((NRW'(lr_r) + NRW'(1)) == nr);

  always_comb begin
    lr_nxt = lr_r;
    lc_nxt = lc_r;
    if (cfg_restart) begin
      lr_nxt = '0;
      lc_nxt = '0;
    end else if (in_acc) begin
      if (row_end) begin
        lc_nxt = '0;
        lr_nxt = is_last ? '0 : lr_r + 1'b1;
      end else begin
        lc_nxt = lc_r + 1'b1;
      end
    end
  end

  assign waddr = AW'(lr_r) * AW'(MAX_COLS) + AW'(lc_r);

  always_comb begin
    if (ctl.op == OP_CHECK) begin
      rd_row = RIW'(i_r);
      rd_col = bc_r;
    end else begin
      rd_row = r_r;
      rd_col = CIW'(i_r);
    end
  end

  assign raddr = AW'(rd_row) * AW'(MAX_COLS) + AW'(rd_col);

  msp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_val   = rdata;
  assign better   = pass_r ? (rd_val > best_r) : (rd_val < best_r);
  assign worse    = pass_r ? (rd_val < best_r) : (rd_val > best_r);
  assign out_free = !out_valid_r || out_ready;
  assign emit_blk = ok_r && pend_valid_r && !out_free;

  assign stat.start     = in_acc && is_last;
  assign stat.loop_more = (ctl.op == OP_SCAN) ? (i_r != LPW'(nc)) : (i_r != LPW'(nr));
  assign stat.emit_blk  = emit_blk;
  assign stat.row_more  = (NRW'(r_r) + NRW'(1)) != nr;
  assign stat.pass0     = !pass_r;
  assign stat.out_busy  = !out_free;

  always_comb begin
    pass_nxt       = pass_r;
    r_nxt          = r_r;
    i_nxt          = i_r;
    best_nxt       = best_r;
    bc_nxt         = bc_r;
    ok_nxt         = ok_r;
    pend_valid_nxt = pend_valid_r;
    pend_val_nxt   = pend_val_r;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    pend_kind_nxt  = pend_kind_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_val_nxt    = out_val_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    case (ctl.op)
      OP_PASS0: begin
        pass_nxt = 1'b0;
        r_nxt    = '0;
      end
      OP_ROWINIT: begin
        i_nxt = '0;
      end
      OP_SCAN: begin
        i_nxt = i_r + 1'b1;
        // read data is registered, so it belongs to the address of the previous cycle
        if (i_r != '0 && (i_r == LPW'(1) || better)) begin
          best_nxt = rd_val;
          bc_nxt   = CIW'(i_r - LPW'(1));
        end
      end
      OP_COLINIT: begin
        i_nxt  = '0;
        ok_nxt = 1'b1;
      end
      OP_CHECK: begin
        i_nxt = i_r + 1'b1;
        if (i_r != '0 && worse) begin
          ok_nxt = 1'b0;
        end
      end
      OP_EMIT: begin
        if (ok_r && !emit_blk) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = pend_val_r;
            out_row_nxt   = pend_row_r;
            out_col_nxt   = pend_col_r;
            out_kind_nxt  = pend_kind_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_val_nxt   = best_r;
          pend_row_nxt   = IDX_OUT_W'(r_r);
          pend_col_nxt   = IDX_OUT_W'(bc_r);
          pend_kind_nxt  = pass_r ? KIND_ROW_MAX : KIND_ROW_MIN;
        end
      end
      OP_NEXTROW: begin
        r_nxt = r_r + 1'b1;
      end
      OP_PASS1: begin
        pass_nxt = 1'b1;
        r_nxt    = '0;
      end
      OP_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_val_nxt  = pend_val_r;
            out_row_nxt  = pend_row_r;
            out_col_nxt  = pend_col_r;
            out_kind_nxt = pend_kind_r;
          end else begin
            out_val_nxt  = '0;
            out_row_nxt  = '0;
            out_col_nxt  = '0;
            out_kind_nxt = KIND_NONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r         <= '0;
      lc_r         <= '0;
      pass_r       <= 1'b0;
      r_r          <= '0;
      i_r          <= '0;
      ok_r         <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      lr_r         <= lr_nxt;
      lc_r         <= lc_nxt;
      pass_r       <= pass_nxt;
      r_r          <= r_nxt;
      i_r          <= i_nxt;
      ok_r         <= ok_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    bc_r        <= bc_nxt;
    pend_val_r  <= pend_val_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_kind_r <= pend_kind_nxt;
    out_val_r   <= out_val_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_point_value = out_val_r;
  assign out_row_index   = out_row_r;
  assign out_col_index   = out_col_r;
  assign out_kind        = out_kind_r;
  assign out_last_result = out_last_r;

endmodule

// ===== design/msp_checker.sv =====
module msp_checker
  import msp_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [VAL_W-1:0] in_element_value,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] out_point_value,
  input logic [IDX_OUT_W-1:0]    out_row_index,
  input logic [IDX_OUT_W-1:0]    out_col_index,
  input logic [KIND_W-1:0]       out_kind,
  input logic                    out_last_result,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data
);

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ROW_MIN || out_kind == KIND_ROW_MAX ||
                   out_kind == KIND_NONE))
    else $error("illegal result kind");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NONE) |->
      (out_last_result && out_point_value == '0 && out_row_index == '0 &&
       out_col_index == '0))
    else $error("none-found result malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_point_value) && $stable(out_kind) &&
       $stable(out_last_result) && $stable(out_row_index) && $stable(out_col_index)))
    else $error("stalled result changed");

endmodule

bind matrix_saddle_point_finder_unit msp_checker u_msp_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  import msp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 12;
  localparam int DRAIN       = 80;
  localparam int LONG_HOLD   = 400;
  localparam int SQUEEZE_N   = 8;
  localparam int RAND_ITEMS  = 130;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  localparam logic signed [VAL_W-1:0] MINV = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MAXV = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_OUT_W-1:0]    row;
    logic [IDX_OUT_W-1:0]    col;
    logic [KIND_W-1:0]       kind;
    logic                    last;
  } point_t;

  typedef enum logic {STEP_CFG, STEP_ELEM} step_t;
  typedef enum logic [1:0] {FILL_NARROW, FILL_WIDE, FILL_EDGE} fill_t;

  typedef struct packed {
    step_t                   act;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    logic signed [VAL_W-1:0] elem;
    logic [1:0]              n_fixed;
    point_t                  fixed0;
    point_t                  fixed1;
  } plan_row_t;

  localparam point_t NO_PT   = '0;
  localparam point_t NONE_PT = '{32'sd0, 4'd0, 4'd0, KIND_NONE, 1'b1};

  localparam plan_row_t PLAN [29] = '{
    '{STEP_CFG,  REG_ROWS,   5'd1, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_CFG,  REG_COLS,   5'd1, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, MAXV,   2'd2,
      '{MAXV, 4'd0, 4'd0, KIND_ROW_MIN, 1'b0}, '{MAXV, 4'd0, 4'd0, KIND_ROW_MAX, 1'b1}},
    '{STEP_ELEM, REG_ROWS,   5'd0, MINV,   2'd2,
      '{MINV, 4'd0, 4'd0, KIND_ROW_MIN, 1'b0}, '{MINV, 4'd0, 4'd0, KIND_ROW_MAX, 1'b1}},
    '{STEP_CFG,  REG_ROWS,   5'd0, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_CFG,  REG_COLS,   5'd0, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd0, 2'd2,
      '{32'sd0, 4'd0, 4'd0, KIND_ROW_MIN, 1'b0}, '{32'sd0, 4'd0, 4'd0, KIND_ROW_MAX, 1'b1}},
    '{STEP_CFG,  REG_ROWS,   5'd2, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_CFG,  REG_COLS,   5'd2, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd5, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd6, 2'd0, NO_PT, NO_PT},
    // rewrite mid-load drops the two elements above
    '{STEP_CFG,  REG_COLS,   5'd2, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd1, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd2, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd3, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd4, 2'd2,
      '{32'sd3, 4'd1, 4'd0, KIND_ROW_MIN, 1'b0}, '{32'sd2, 4'd0, 4'd1, KIND_ROW_MAX, 1'b1}},
    '{STEP_CFG,  REG_SPARE3, 5'd0, 32'sd0, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd1, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd2, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd2, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd1, 2'd1, NONE_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, MINV,   2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, MAXV,   2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, MAXV,   2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, MINV,   2'd1, NONE_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd7, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd7, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd7, 2'd0, NO_PT, NO_PT},
    '{STEP_ELEM, REG_ROWS,   5'd0, 32'sd7, 2'd0, NO_PT, NO_PT}
  };

  localparam logic [CFG_DATA_W-1:0] SHAPE_R [4] = '{5'd31, 5'd1, 5'd16, 5'd2};
  localparam logic [CFG_DATA_W-1:0] SHAPE_C [4] = '{5'd1, 5'd17, 5'd2, 5'd16};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_point_value;
  logic [IDX_OUT_W-1:0]    out_row_index;
  logic [IDX_OUT_W-1:0]    out_col_index;
  logic [KIND_W-1:0]       out_kind;
  logic                    out_last_result;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  logic signed [VAL_W-1:0] grid [MAX_ROWS_DEF][MAX_COLS_DEF];
  logic [CFG_DATA_W-1:0]   rows_cfg;
  logic [CFG_DATA_W-1:0]   cols_cfg;
  int                      fill_pos;
  point_t                  fresh_q [$];
  point_t                  pending_q [$];
  point_t                  due;
  bit                      squeeze = 1'b0;
  int                      points_seen = 0;
  int                      mismatches = 0;
  int                      cycle_cnt = 0;

  matrix_saddle_point_finder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_value  (out_point_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_kind         (out_kind),
    .out_last_result  (out_last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_dim(logic [CFG_DATA_W-1:0] v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 5'($urandom_range(1, 4));
    if (r < 85) return 5'($urandom_range(5, 8));
    if (r < 92) return 5'd0;
    return 5'($urandom_range(16, 31));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value(fill_t mode);
    case (mode)
      FILL_NARROW: return $signed($urandom_range(0, 6)) - 3;
      FILL_WIDE:   return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return MINV;
          1: return MAXV;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  // store one element; on the last one of the matrix, run both searches into fresh_q
  task automatic absorb_element(logic signed [VAL_W-1:0] v);
    int nr, nc, r, c, rr, pick;
    bit hit;
    logic signed [VAL_W-1:0] pivot;
    point_t p;
    nr = eff_dim(rows_cfg, MAX_ROWS_DEF);
    nc = eff_dim(cols_cfg, MAX_COLS_DEF);
    fresh_q.delete();
    if (fill_pos >= nr * nc) fill_pos = 0;
    grid[fill_pos / nc][fill_pos % nc] = v;
    fill_pos++;
    if (fill_pos < nr * nc) return;
    fill_pos = 0;
    for (int want_max = 0; want_max < 2; want_max++) begin
      for (r = 0; r < nr; r++) begin
        pick = 0;
        for (c = 1; c < nc; c++) begin
          if (want_max ? grid[r][c] > grid[r][pick] : grid[r][c] < grid[r][pick]) pick = c;
        end
        pivot = grid[r][pick];
        hit = 1'b1;
        for (rr = 0; rr < nr; rr++) begin
          if (want_max ? grid[rr][pick] < pivot : grid[rr][pick] > pivot) hit = 1'b0;
        end
        if (hit) begin
          p.value = pivot;
          p.row   = 4'(r);
          p.col   = 4'(pick);
          p.kind  = want_max ? KIND_ROW_MAX : KIND_ROW_MIN;
          p.last  = 1'b0;
          fresh_q.push_back(p);
        end
      end
    end
    if (fresh_q.size() == 0) fresh_q.push_back(NONE_PT);
    fresh_q[fresh_q.size() - 1].last = 1'b1;
  endtask

  task automatic send_element(logic signed [VAL_W-1:0] v, int gap, bit own);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (!in_ready);
    absorb_element(v);
    if (!own) begin
      foreach (fresh_q[i]) pending_q.push_back(fresh_q[i]);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROWS: begin
        rows_cfg = val;
        fill_pos = 0;
      end
      REG_COLS: begin
        cols_cfg = val;
        fill_pos = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("MISMATCH %s", msg);
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      points_seen++;
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("point %0d r%0d c%0d kind %0d with none pending",
                                out_point_value, out_row_index, out_col_index, out_kind));
      end else begin
        due = pending_q.pop_front();
        if (out_point_value !== due.value)
          flag_mismatch($sformatf("#%0d value %0d, want %0d", points_seen,
                                  out_point_value, due.value));
        if (out_row_index !== due.row)
          flag_mismatch($sformatf("#%0d row %0d, want %0d", points_seen,
                                  out_row_index, due.row));
        if (out_col_index !== due.col)
          flag_mismatch($sformatf("#%0d col %0d, want %0d", points_seen,
                                  out_col_index, due.col));
        if (out_kind !== due.kind)
          flag_mismatch($sformatf("#%0d kind %0d, want %0d", points_seen,
                                  out_kind, due.kind));
        if (out_last_result !== due.last)
          flag_mismatch($sformatf("#%0d last %0d, want %0d", points_seen,
                                  out_last_result, due.last));
      end
    end
  end

  initial begin : sink
    int stall;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      // long hold-off so results back up and the block stops taking requests
      if (!held && squeeze) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  initial begin : stimulus
    int rand_elems, round, total, k;
    fill_t mode;
    rows_cfg = SIZE_RESET;
    cols_cfg = SIZE_RESET;
    fill_pos = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].act == STEP_CFG) begin
        write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        send_element(PLAN[i].elem, pick_gap(), PLAN[i].n_fixed != 0);
        if (PLAN[i].n_fixed > 0) pending_q.push_back(PLAN[i].fixed0);
        if (PLAN[i].n_fixed > 1) pending_q.push_back(PLAN[i].fixed1);
      end
    end

    // 1x1 burst while the sink holds off
    write_reg(REG_ROWS, 5'd1);
    write_reg(REG_COLS, 5'd1);
    squeeze = 1'b1;
    repeat (SQUEEZE_N) send_element(pick_value(FILL_WIDE), 0, 1'b0);

    rand_elems = 0;
    round = 0;
    while (rand_elems < RAND_ITEMS) begin
      if (round < 4) begin
        write_reg(REG_ROWS, SHAPE_R[round]);
        write_reg(REG_COLS, SHAPE_C[round]);
      end else begin
        if ($urandom_range(0, 2) == 0) write_reg(REG_ROWS, pick_size());
        if ($urandom_range(0, 2) == 0) write_reg(REG_COLS, pick_size());
        if ($urandom_range(0, 7) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, 5'($urandom_range(0, 31)));
      end
      mode = fill_t'($urandom_range(0, 2));
      total = eff_dim(rows_cfg, MAX_ROWS_DEF) * eff_dim(cols_cfg, MAX_COLS_DEF);
      // abandoned load: a few elements, then a size write restarts the matrix
      if (round >= 4 && total > 1 && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(1, (total < 8) ? total - 1 : 7);
        repeat (k) send_element(pick_value(mode), pick_gap(), 1'b0);
        rand_elems += k;
        write_reg($urandom_range(0, 1) ? REG_ROWS : REG_COLS, pick_size());
        total = eff_dim(rows_cfg, MAX_ROWS_DEF) * eff_dim(cols_cfg, MAX_COLS_DEF);
      end
      // keep the request count near its budget
      if (rand_elems + total > RAND_ITEMS + 16) begin
        write_reg(REG_ROWS, 5'd1);
        total = eff_dim(cols_cfg, MAX_COLS_DEF);
      end
      repeat (total) begin
        send_element(pick_value(mode), pick_gap(), 1'b0);
        rand_elems++;
      end
      round++;
    end

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
